### hdl/assert_macros.svh
// Assertion macros shared by the RTL; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge outside reset.
`define AST_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define AST_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define AST_ALWAYS(lbl, clk, rst, cond)
`define AST_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### hdl/dlfm_pkg.sv
// Types and constants for the decimal list filter match unit.
`timescale 1ns / 1ps

package dlfm_pkg;

  localparam int unsigned WANTED_W = 31;
  localparam int unsigned MAG_W    = 32;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [MAG_W-1:0] MAG_LIMIT = 32'h8000_0000;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_BROKEN = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic list_valid;
    logic list_matches;
  } result_t;

  typedef struct packed {
    logic ok;
    logic hit;
  } tok_check_t;

endpackage

### hdl/decimal_list_filter_match_unit.sv
// Decimal list filter match unit: parses a comma-separated number list per byte.
`timescale 1ns / 1ps

// Takes one byte word per cycle on the item channel, with last marking the
// final byte of a list. Leading whitespace, an optional sign and one or more
// digits form a token; a token is valid for values -1 .. 2147483647. On the
// word with last set, one result word is registered for the result channel:
// list_valid (all tokens valid) and list_matches (valid, and some token is -1
// or equals wanted_number). Throughput is one byte per cycle; the only loop is
// the per-byte token state update (times-ten add with saturation). A two-entry
// result buffer lets bytes keep flowing while a result waits; item_ready drops
// only when both entries hold undelivered results. wanted_number is written
// by the user on cfg_we/cfg_wdata only while the block is idle (not enforced).

`include "assert_macros.svh"

module decimal_list_filter_match_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dlfm_pkg::WANTED_W-1:0]   cfg_wdata,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  dlfm_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output dlfm_pkg::result_t               result
);

  // configuration
  logic [dlfm_pkg::WANTED_W-1:0] wanted_number;

  // running token / list state
  dlfm_pkg::phase_t              phase, phase_next;
  logic                          negative, negative_next;
  logic [dlfm_pkg::MAG_W-1:0]    magnitude, magnitude_next;
  logic                          all_valid, all_valid_next;
  logic                          any_match, any_match_next;

  // result buffer: main output register plus skid entry
  logic                          out_valid;
  dlfm_pkg::result_t             out_word;
  logic                          skid_valid;
  dlfm_pkg::result_t             skid_word;

  logic                          accept;
  logic                          pop;
  logic                          is_comma, is_digit, is_space, is_sign;
  logic [3:0]                    digit;
  logic [dlfm_pkg::MAG_W+3:0]    mag_x10;
  logic [dlfm_pkg::MAG_W-1:0]    mag_sat;
  dlfm_pkg::tok_check_t          chk_a, chk_b;
  dlfm_pkg::result_t             new_word;

  // Validity and match of a finished token.
  function automatic dlfm_pkg::tok_check_t check_token(
    input dlfm_pkg::phase_t              ph,
    input logic                          neg,
    input logic [dlfm_pkg::MAG_W-1:0]    mag,
    input logic [dlfm_pkg::WANTED_W-1:0] want
  );
    dlfm_pkg::tok_check_t r;
    r.ok  = 1'b0;
    r.hit = 1'b0;
    if (ph == dlfm_pkg::PH_DIGITS) begin
      if (neg) begin
        if (mag == dlfm_pkg::MAG_W'(1)) begin
          r.ok  = 1'b1;
          r.hit = 1'b1;
        end else if (mag == '0) begin
          r.ok  = 1'b1;
          r.hit = (want == '0);
        end
      end else if (mag < dlfm_pkg::MAG_LIMIT) begin
        r.ok  = 1'b1;
        r.hit = (mag == {1'b0, want});
      end
    end
    return r;
  endfunction

  assign accept     = item_valid && item_ready;
  assign item_ready = !skid_valid;
  assign pop        = result_valid && result_ready;

  // byte classes
  assign is_comma = (item.ch == dlfm_pkg::CH_COMMA);
  assign is_digit = (item.ch >= dlfm_pkg::CH_ZERO) && (item.ch <= dlfm_pkg::CH_NINE);
  assign is_space = (item.ch == dlfm_pkg::CH_SPACE) ||
                    ((item.ch >= dlfm_pkg::CH_TAB) && (item.ch <= dlfm_pkg::CH_CR));
  assign is_sign  = (item.ch == dlfm_pkg::CH_PLUS) || (item.ch == dlfm_pkg::CH_MINUS);
  assign digit    = item.ch[3:0];

  // magnitude * 10 + digit as shift-add, saturating at 2^31
  assign mag_x10 = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0} +
                   {32'd0, digit};
  assign mag_sat = (mag_x10 > {4'd0, dlfm_pkg::MAG_LIMIT}) ? dlfm_pkg::MAG_LIMIT
                                                          : mag_x10[dlfm_pkg::MAG_W-1:0];

  // comma closes the current token
  assign chk_a = check_token(phase, negative, magnitude, wanted_number);

  // next state of the token and list
  always_comb begin
    phase_next     = phase;
    negative_next  = negative;
    magnitude_next = magnitude;
    all_valid_next = all_valid;
    any_match_next = any_match;

    if (is_comma) begin
      if (!chk_a.ok) begin
        all_valid_next = 1'b0;
      end else if (chk_a.hit) begin
        any_match_next = 1'b1;
      end
      phase_next     = dlfm_pkg::PH_START;
      negative_next  = 1'b0;
      magnitude_next = '0;
    end else begin
      unique case (phase)
        dlfm_pkg::PH_START: begin
          priority if (is_space) begin
            phase_next = dlfm_pkg::PH_START;
          end else if (is_sign) begin
            negative_next = (item.ch == dlfm_pkg::CH_MINUS);
            phase_next    = dlfm_pkg::PH_SIGN;
          end else if (is_digit) begin
            magnitude_next = {28'd0, digit};
            phase_next     = dlfm_pkg::PH_DIGITS;
          end else begin
            phase_next = dlfm_pkg::PH_BROKEN;
          end
        end
        dlfm_pkg::PH_SIGN, dlfm_pkg::PH_DIGITS: begin
          if (is_digit) begin
            magnitude_next = mag_sat;
            phase_next     = dlfm_pkg::PH_DIGITS;
          end else begin
            phase_next = dlfm_pkg::PH_BROKEN;
          end
        end
        default: begin
          phase_next = dlfm_pkg::PH_BROKEN;
        end
      endcase
    end
  end

  // final byte closes the last token (empty after a trailing comma)
  assign chk_b = check_token(phase_next, negative_next, magnitude_next, wanted_number);

  always_comb begin
    new_word.list_valid   = all_valid_next && chk_b.ok;
    new_word.list_matches = all_valid_next && chk_b.ok && (any_match_next || chk_b.hit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_number <= '0;
    end else if (cfg_we) begin
      wanted_number <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= dlfm_pkg::PH_START;
      negative  <= 1'b0;
      magnitude <= '0;
      all_valid <= 1'b1;
      any_match <= 1'b0;
    end else if (accept) begin
      if (item.last) begin
        // list done: back to a fresh list
        phase     <= dlfm_pkg::PH_START;
        negative  <= 1'b0;
        magnitude <= '0;
        all_valid <= 1'b1;
        any_match <= 1'b0;
      end else begin
        phase     <= phase_next;
        negative  <= negative_next;
        magnitude <= magnitude_next;
        all_valid <= all_valid_next;
        any_match <= any_match_next;
      end
    end
  end

  // result buffer control; skid only fills while the output word is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept && item.last;
        end
      end else if (accept && item.last) begin
        if (!out_valid) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word <= skid_valid ? skid_word : new_word;
    end else if (accept && item.last) begin
      if (!out_valid) begin
        out_word <= new_word;
      end else begin
        skid_word <= new_word;
      end
    end
  end

  assign result_valid = out_valid;
  assign result       = out_word;

  // assertions
  `AST_ALWAYS(a_skid_behind_out, clk, rst, !skid_valid || out_valid)
  `AST_ALWAYS(a_match_needs_valid, clk, rst, !out_valid || !out_word.list_matches || out_word.list_valid)
  `AST_NEXT(a_last_gives_result, clk, rst, accept && item.last, out_valid)
  `AST_NEXT(a_last_clears_list, clk, rst, accept && item.last, (phase == dlfm_pkg::PH_START) && (magnitude == '0) && all_valid && !any_match)

endmodule
